[rtl/core/ps2_set1_scancode_decoder_defines.svh]
// Assertion macros for the scancode decoder RTL.
`ifndef PS2_SET1_SCANCODE_DECODER_DEFINES_SVH
`define PS2_SET1_SCANCODE_DECODER_DEFINES_SVH

// Implication checked on every rising clk edge, off while in reset.
`define PS2S1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked while reset is held.
`define PS2S1_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ps2s1_pkg.sv]
// Types, scancode constants and key tables for the set-1 scancode decoder.
`timescale 1ns / 1ps

package ps2s1_pkg;

  typedef enum logic [3:0] {
    EV_CHAR  = 4'd0,
    EV_ENTER = 4'd1,
    EV_BS    = 4'd2,
    EV_TAB   = 4'd3,
    EV_ESC   = 4'd4,
    EV_LEFT  = 4'd5,
    EV_RIGHT = 4'd6,
    EV_UP    = 4'd7,
    EV_DOWN  = 4'd8,
    EV_HOME  = 4'd9,
    EV_END   = 4'd10,
    EV_DEL   = 4'd11,
    EV_PGUP  = 4'd12,
    EV_PGDN  = 4'd13
  } event_kind_t;

  // Prefix bytes
  localparam logic [7:0] SC_EXT0 = 8'hE0;
  localparam logic [7:0] SC_EXT1 = 8'hE1;

  // Make codes (break flag stripped)
  localparam logic [6:0] CODE_ESC    = 7'h01;
  localparam logic [6:0] CODE_BS     = 7'h0E;
  localparam logic [6:0] CODE_TAB    = 7'h0F;
  localparam logic [6:0] CODE_ENTER  = 7'h1C;
  localparam logic [6:0] CODE_CTRL   = 7'h1D;
  localparam logic [6:0] CODE_LSHIFT = 7'h2A;
  localparam logic [6:0] CODE_RSHIFT = 7'h36;
  localparam logic [6:0] CODE_ALT    = 7'h38;
  localparam logic [6:0] CODE_CAPS   = 7'h3A;
  localparam logic [6:0] CODE_HOME   = 7'h47;
  localparam logic [6:0] CODE_UP     = 7'h48;
  localparam logic [6:0] CODE_PGUP   = 7'h49;
  localparam logic [6:0] CODE_LEFT   = 7'h4B;
  localparam logic [6:0] CODE_RIGHT  = 7'h4D;
  localparam logic [6:0] CODE_END    = 7'h4F;
  localparam logic [6:0] CODE_DOWN   = 7'h50;
  localparam logic [6:0] CODE_PGDN   = 7'h51;
  localparam logic [6:0] CODE_DEL    = 7'h53;

  // Modifier bit positions
  localparam int unsigned MB_SHIFT = 0;
  localparam int unsigned MB_CTRL  = 1;
  localparam int unsigned MB_ALT   = 2;
  localparam int unsigned MB_CAPS  = 3;

  localparam int unsigned TAB_LEN = 64;

  // US layout, unshifted; zero marks no printable key
  localparam logic [6:0] PLAIN_TAB [TAB_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // US layout, shifted; letters here are the upper-case forms
  localparam logic [6:0] SHIFT_TAB [TAB_LEN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic       ext;   // E0 seen, next code is extended
    logic [3:0] mods;  // caps, alt, ctrl, shift
  } ps2s1_state_t;

  typedef struct packed {
    logic        vld;
    event_kind_t kind;
    logic [6:0]  ch;
    logic [3:0]  mods;
  } ps2s1_event_t;

  function automatic logic is_letter(input logic [5:0] idx);
    return (idx >= 6'h10 && idx <= 6'h19) || (idx >= 6'h1E && idx <= 6'h26) ||
           (idx >= 6'h2C && idx <= 6'h32);
  endfunction

endpackage

[rtl/core/ps2s1_decode.sv]
// Combinational decode of one scancode byte against the modifier and prefix state.
`timescale 1ns / 1ps

module ps2s1_decode (
  input  logic [7:0]              scan_byte,
  input  ps2s1_pkg::ps2s1_state_t st,
  output ps2s1_pkg::ps2s1_state_t st_nxt,
  output ps2s1_pkg::ps2s1_event_t ev
);
  import ps2s1_pkg::*;

  logic       brk;
  logic [6:0] code;
  logic       upper;
  logic [6:0] tab_ch;

  assign brk  = scan_byte[7];
  assign code = scan_byte[6:0];

  // letters follow shift XOR caps, everything else shift alone
  assign upper  = is_letter(code[5:0]) ? (st.mods[MB_SHIFT] ^ st.mods[MB_CAPS])
                                       : st.mods[MB_SHIFT];
  assign tab_ch = upper ? SHIFT_TAB[code[5:0]] : PLAIN_TAB[code[5:0]];

  always_comb begin
    st_nxt  = st;
    ev      = '0;
    ev.kind = EV_CHAR;
    ev.mods = st.mods;
    priority if (scan_byte == SC_EXT0) begin
      st_nxt.ext = 1'b1;
    end else if (scan_byte == SC_EXT1) begin
      st_nxt = st;
    end else if (!st.ext && (code == CODE_LSHIFT || code == CODE_RSHIFT)) begin
      st_nxt.mods[MB_SHIFT] = !brk;
      st_nxt.ext            = 1'b0;
    end else if (code == CODE_CTRL) begin
      // right ctrl arrives as E0 1D and counts the same
      st_nxt.mods[MB_CTRL] = !brk;
      st_nxt.ext           = 1'b0;
    end else if (code == CODE_ALT) begin
      st_nxt.mods[MB_ALT] = !brk;
      st_nxt.ext          = 1'b0;
    end else if (!st.ext && code == CODE_CAPS && !brk) begin
      st_nxt.mods[MB_CAPS] = !st.mods[MB_CAPS];
    end else if (brk) begin
      st_nxt.ext = 1'b0;
    end else if (st.ext) begin
      st_nxt.ext = 1'b0;
      ev.vld     = 1'b1;
      unique case (code)
        CODE_LEFT:  ev.kind = EV_LEFT;
        CODE_RIGHT: ev.kind = EV_RIGHT;
        CODE_UP:    ev.kind = EV_UP;
        CODE_DOWN:  ev.kind = EV_DOWN;
        CODE_HOME:  ev.kind = EV_HOME;
        CODE_END:   ev.kind = EV_END;
        CODE_DEL:   ev.kind = EV_DEL;
        CODE_PGUP:  ev.kind = EV_PGUP;
        CODE_PGDN:  ev.kind = EV_PGDN;
        default:    ev.vld  = 1'b0;
      endcase
    end else begin
      ev.vld = 1'b1;
      unique case (code)
        CODE_ESC:   ev.kind = EV_ESC;
        CODE_BS:    ev.kind = EV_BS;
        CODE_TAB:   ev.kind = EV_TAB;
        CODE_ENTER: ev.kind = EV_ENTER;
        default: begin
          // codes past the table, and empty entries, give nothing
          ev.ch  = code[6] ? 7'd0 : tab_ch;
          ev.vld = !code[6] && (tab_ch != 7'd0);
        end
      endcase
    end
  end

endmodule

[rtl/core/ps2_set1_scancode_decoder.sv]
// Top level of the PS/2 set-1 scancode to key event decoder.
`timescale 1ns / 1ps
`include "ps2_set1_scancode_decoder_defines.svh"

// Takes one raw set-1 scancode byte per request and returns at most one key
// event (char, enter, backspace, tab, esc or an extended navigation key) with
// the shift/ctrl/alt/caps state at that moment. Breaks, prefixes, modifiers
// and unknown codes give no result. One byte is taken every cycle when the
// result side keeps up; each byte passes the input register, then decode
// into the result register. The rate rests on the update of the modifier
// and E0-prefix flags, which each byte reads and rewrites as it is taken.
module ps2_set1_scancode_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_event_kind,
  output logic [6:0] out_char_code,
  output logic [3:0] out_modifier_bits
);
  import ps2s1_pkg::*;

  logic         s1_vld_r;
  logic [7:0]   s1_byte_r;
  ps2s1_state_t st_r;
  ps2s1_state_t st_nxt;
  ps2s1_event_t ev;
  logic         out_vld_r;
  logic [3:0]   out_kind_r;
  logic [6:0]   out_ch_r;
  logic [3:0]   out_mods_r;
  logic         out_free;
  logic         s1_take;

  ps2s1_decode u_decode (
    .scan_byte (s1_byte_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .ev        (ev)
  );

  assign out_free = !out_vld_r || out_ready;
  // a byte without an event never waits on the result side
  assign s1_take  = s1_vld_r && (!ev.vld || out_free);
  assign in_ready = !s1_vld_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s1_take) begin
        st_r <= st_nxt;
      end
      if (s1_take && ev.vld) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_scan_byte;
    end
    if (s1_take && ev.vld) begin
      out_kind_r <= ev.kind;
      out_ch_r   <= ev.ch;
      out_mods_r <= ev.mods;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_kind    = out_kind_r;
  assign out_char_code     = out_ch_r;
  assign out_modifier_bits = out_mods_r;

  `PS2S1_ASSERT(a_char_zero_else, out_vld_r && out_kind_r != EV_CHAR |-> out_ch_r == 7'd0, "non-char event carries a character")
  `PS2S1_ASSERT(a_char_nonzero, out_vld_r && out_kind_r == EV_CHAR |-> out_ch_r != 7'd0, "char event with null character")
  `PS2S1_ASSERT(a_e0_sets_ext, s1_take && s1_byte_r == SC_EXT0 |=> st_r.ext, "E0 prefix did not set extended flag")
  `PS2S1_ASSERT(a_e1_no_change, s1_take && s1_byte_r == SC_EXT1 |=> $stable(st_r), "E1 byte changed decoder state")
  `PS2S1_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_vld_r && !s1_vld_r && st_r == '0, "reset left state behind")

endmodule

[dv/ps2s1_event_checker.sv]
// Checker for the set-1 scancode decoder: predicts key events and compares them.
`timescale 1ns / 1ps

module ps2s1_event_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_scan_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_event_kind,
  input  logic [6:0] out_char_code,
  input  logic [3:0] out_modifier_bits,
  output int         fail_count,
  output int         pending,
  output int         events_checked
);
  import ps2s1_pkg::*;

  typedef struct {
    event_kind_t kind;
    logic [6:0]  ch;
    logic [3:0]  mods;
  } exp_event_t;

  // US layout by make code; '.' fills slots that never reach the char path
  string plain_keys   = "..1234567890-=..qwertyuiop[]..asdfghjkl;'`.\\zxcvbnm,./.*. .";
  string shifted_keys = "..!@#$%^&*()_+..QWERTYUIOP{}..ASDFGHJKL:\"~.|ZXCVBNM<>?.*. .";

  logic [3:0] held_mods;
  logic       ext_pending;
  exp_event_t expected_events[$];

  initial begin
    fail_count     = 0;
    pending        = 0;
    events_checked = 0;
    held_mods      = '0;
    ext_pending    = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Applies one scancode to the key state; returns 1 when a key event follows.
  function automatic bit decode_scan_byte(input logic [7:0] sc, output exp_event_t ev);
    logic       brk;
    logic [6:0] code;
    logic       upper;
    byte        ch;
    ev.kind = EV_CHAR;
    ev.ch   = '0;
    ev.mods = '0;
    if (sc == SC_EXT0) begin
      ext_pending = 1'b1;
      return 1'b0;
    end
    if (sc == SC_EXT1) return 1'b0;
    brk  = sc[7];
    code = sc[6:0];
    // extended shift codes are not shift at all
    if (!ext_pending && (code == CODE_LSHIFT || code == CODE_RSHIFT)) begin
      held_mods[MB_SHIFT] = !brk;
      ext_pending = 1'b0;
      return 1'b0;
    end
    if (code == CODE_CTRL) begin
      held_mods[MB_CTRL] = !brk;
      ext_pending = 1'b0;
      return 1'b0;
    end
    if (code == CODE_ALT) begin
      held_mods[MB_ALT] = !brk;
      ext_pending = 1'b0;
      return 1'b0;
    end
    if (!ext_pending && code == CODE_CAPS && !brk) begin
      held_mods[MB_CAPS] = !held_mods[MB_CAPS];
      return 1'b0;
    end
    if (brk) begin
      ext_pending = 1'b0;
      return 1'b0;
    end
    ev.mods = held_mods;
    if (ext_pending) begin
      ext_pending = 1'b0;
      case (code)
        CODE_LEFT:  ev.kind = EV_LEFT;
        CODE_RIGHT: ev.kind = EV_RIGHT;
        CODE_UP:    ev.kind = EV_UP;
        CODE_DOWN:  ev.kind = EV_DOWN;
        CODE_HOME:  ev.kind = EV_HOME;
        CODE_END:   ev.kind = EV_END;
        CODE_DEL:   ev.kind = EV_DEL;
        CODE_PGUP:  ev.kind = EV_PGUP;
        CODE_PGDN:  ev.kind = EV_PGDN;
        default:    return 1'b0;
      endcase
      return 1'b1;
    end
    case (code)
      CODE_ESC: begin
        ev.kind = EV_ESC;
        return 1'b1;
      end
      CODE_BS: begin
        ev.kind = EV_BS;
        return 1'b1;
      end
      CODE_TAB: begin
        ev.kind = EV_TAB;
        return 1'b1;
      end
      CODE_ENTER: begin
        ev.kind = EV_ENTER;
        return 1'b1;
      end
      default: ;
    endcase
    if (code == '0 || code >= CODE_CAPS) return 1'b0;
    ch = plain_keys[code];
    if (ch >= "a" && ch <= "z") begin
      upper = held_mods[MB_SHIFT] ^ held_mods[MB_CAPS];
      if (upper) ch = ch - ("a" - "A");
    end else if (held_mods[MB_SHIFT]) begin
      ch = shifted_keys[code];
    end
    ev.kind = EV_CHAR;
    ev.ch   = ch[6:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    exp_event_t ev;
    exp_event_t want;
    if (!rst_n) begin
      held_mods   = '0;
      ext_pending = 1'b0;
      expected_events.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (decode_scan_byte(in_scan_byte, ev)) expected_events.push_back(ev);
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          flag_mismatch($sformatf("key event kind %0d with none expected", out_event_kind));
        end else begin
          want = expected_events.pop_front();
          events_checked++;
          if (out_event_kind !== want.kind)
            flag_mismatch($sformatf("event kind %0d, want %0d", out_event_kind, want.kind));
          if (out_char_code !== want.ch)
            flag_mismatch($sformatf("char code %h, want %h", out_char_code, want.ch));
          if (out_modifier_bits !== want.mods)
            flag_mismatch($sformatf("modifiers %b, want %b", out_modifier_bits, want.mods));
        end
      end
    end
    pending <= expected_events.size();
  end

endmodule

[dv/testbench.sv]
// Top of the scancode decoder bench: clock, reset, scancode stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import ps2s1_pkg::*;

  localparam int ITEMS_TARGET = 1350;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] BRK       = 8'h80;
  localparam logic [7:0] SC_ZERO   = 8'h00;
  localparam logic [7:0] SC_TOP    = 8'hFF;
  localparam logic [6:0] CODE_1    = 7'h02;
  localparam logic [6:0] CODE_Q    = 7'h10;
  localparam logic [6:0] CODE_A    = 7'h1E;
  localparam logic [6:0] CODE_SPC  = 7'h39;
  localparam logic [6:0] CODE_F1   = 7'h3B;
  localparam logic [6:0] CODE_NUML = 7'h45;
  localparam logic [6:0] CODE_LAST = 7'h7F;

  localparam logic [6:0] NAV_KEYS [9] = '{CODE_LEFT, CODE_RIGHT, CODE_UP, CODE_DOWN,
    CODE_HOME, CODE_END, CODE_DEL, CODE_PGUP, CODE_PGDN};
  localparam logic [6:0] MOD_KEYS [5] = '{CODE_LSHIFT, CODE_RSHIFT, CODE_CTRL, CODE_ALT,
    CODE_CAPS};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_event_kind;
  logic [6:0] out_char_code;
  logic [3:0] out_modifier_bits;

  int fail_count;
  int pending;
  int events_checked;
  int bytes_sent = 0;
  int e1_sent = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ps2_set1_scancode_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_scan_byte     (in_scan_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_char_code    (out_char_code),
    .out_modifier_bits(out_modifier_bits)
  );

  ps2s1_event_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_scan_byte     (in_scan_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_char_code    (out_char_code),
    .out_modifier_bits(out_modifier_bits),
    .fail_count       (fail_count),
    .pending          (pending),
    .events_checked   (events_checked)
  );

  // result side back-pressure in short bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one request; returns at the edge where it is taken
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_scan_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b == SC_EXT1) e1_sent++;
    else bytes_sent++;
    // quiet spells every so often, and none at all near the end
    idle_on = (bytes_sent < ITEMS_TARGET - CALM_TAIL) && ((bytes_sent / 120) % 3 != 2);
  endtask

  task automatic send_make(input logic [6:0] code);
    send_byte({1'b0, code});
  endtask

  task automatic send_break(input logic [6:0] code);
    send_byte(BRK | {1'b0, code});
  endtask

  task automatic type_random_burst();
    logic [6:0] code;
    logic [7:0] raw;
    int         pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      // key tap, mostly within the table
      code = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 63));
      send_make(code);
      if ($urandom_range(0, 3) != 0) send_break(code);
    end else if (pick < 11) begin
      code = MOD_KEYS[$urandom_range(0, 4)];
      if ($urandom_range(0, 3) == 0) send_byte(SC_EXT0);
      if ($urandom_range(0, 2) != 0) send_make(code);
      if ($urandom_range(0, 2) != 0) send_break(code);
    end else if (pick < 15) begin
      code = NAV_KEYS[$urandom_range(0, 8)];
      send_byte(SC_EXT0);
      send_make(code);
      if ($urandom_range(0, 1) != 0) begin
        send_byte(SC_EXT0);
        send_break(code);
      end
    end else if (pick < 17) begin
      send_byte(SC_EXT0);
      raw = 8'($urandom_range(0, 255));
      send_byte(raw);
    end else if (pick == 17) begin
      // pause key sequence
      send_byte(SC_EXT1);
      send_make(CODE_CTRL);
      send_make(CODE_NUML);
      send_byte(SC_EXT1);
      send_break(CODE_CTRL);
      send_break(CODE_NUML);
    end else begin
      raw = 8'($urandom_range(0, 255));
      send_byte(raw);
    end
  endtask

  initial begin
    #2_000_000;
    $display("timeout: %0d events still outstanding", pending);
    $display("FAIL ps2_set1_scancode_decoder");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: extremes, each plain key kind, modifiers and prefix cases
    send_byte(SC_ZERO);
    send_make(CODE_ESC);
    send_make(CODE_BS);
    send_make(CODE_TAB);
    send_make(CODE_ENTER);
    send_make(CODE_A);
    send_make(CODE_CAPS);
    send_make(CODE_A);
    send_make(CODE_LSHIFT);
    send_make(CODE_1);
    send_make(CODE_Q);
    send_break(CODE_LSHIFT);
    send_byte(SC_EXT0);
    send_make(CODE_LSHIFT);
    send_make(CODE_F1);
    send_byte(SC_EXT0);
    send_make(CODE_CTRL);
    send_byte(SC_EXT0);
    send_make(CODE_ALT);
    send_byte(SC_EXT0);
    send_make(CODE_CAPS);
    send_byte(SC_EXT0);
    send_byte(SC_EXT1);
    send_make(CODE_DEL);
    send_byte(SC_EXT0);
    send_make(CODE_LAST);
    send_byte(SC_TOP);
    send_break(CODE_CTRL);
    send_break(CODE_ALT);
    send_make(CODE_CAPS);
    send_make(CODE_SPC);

    while (bytes_sent < ITEMS_TARGET) type_random_burst();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d scancode bytes plus %0d E1 prefixes; %0d key events compared.",
             bytes_sent, e1_sent, events_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS ps2_set1_scancode_decoder");
    end else begin
      $display("%0d mismatches, %0d events never delivered", fail_count, pending);
      $display("FAIL ps2_set1_scancode_decoder");
    end
    $finish;
  end

endmodule

[ps2_set1_scancode_decoder.f]
+incdir+rtl/core
rtl/core/ps2s1_pkg.sv
rtl/core/ps2s1_decode.sv
rtl/core/ps2_set1_scancode_decoder.sv
dv/ps2s1_event_checker.sv
dv/testbench.sv
